@@ hw/rtl/kcl_pkg.sv @@
// kcl_pkg: shared constants for the keyframe curve interpolator
// used by kcl_div and keyframe_curve_lerp; no dependencies
package kcl_pkg;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic       OP_INSERT = 1'b0;
    localparam logic       OP_EVAL   = 1'b1;
    localparam int         QW = 33;  // width of dt and span (exact difference)
    localparam int         FW = 17;  // frac width, 0..65536
endpackage

@@ hw/rtl/kcl_div.sv @@
// kcl_div: restoring divider giving min(floor(dt*65536/span), 65536)
// one quotient bit per cycle; uses kcl_pkg
module kcl_div
    import kcl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_dt,
    input  logic [QW-1:0] i_span,
    output logic          o_done,
    output logic [FW-1:0] o_frac
);
    // dt <= span so the quotient fits in 17 bits; 17 steps
    logic [QW:0]   r_rem;
    logic [QW-1:0] r_den;
    logic [FW-1:0] r_quo;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic [QW:0]   w_sh;
    logic [QW:0]   w_sub;

    assign w_sh  = {r_rem[QW-1:0], 1'b0};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_den  <= i_span;
                // first quotient bit (weight 65536): dt >= span
                if (i_dt >= i_span) begin
                    r_quo <= {1'b1, 16'd0};
                    r_rem <= {1'b0, i_dt - i_span};
                end else begin
                    r_quo <= '0;
                    r_rem <= {1'b0, i_dt};
                end
            end else if (r_busy) begin
                if (!w_sub[QW]) begin
                    r_rem <= w_sub;
                    r_quo <= {r_quo[FW-2:0], 1'b1} | (r_quo & {1'b1, 16'd0});
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[FW-2:0], 1'b0} | (r_quo & {1'b1, 16'd0});
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // with top bit set dt==span so all low bits are zero; clamp anyway
    assign o_frac = r_quo[FW-1] ? {1'b1, 16'd0} : r_quo;
endmodule

@@ hw/rtl/keyframe_curve_lerp.sv @@
// keyframe_curve_lerp: time-sorted keyframe table with linear interpolation
// top level; uses kcl_pkg and kcl_div
//
// Input channel (i_valid/o_stall) carries op, time and value. op insert puts
// a keyframe after all entries of equal or lower time; op evaluate returns
// the interpolated curve value at the given time. Each transfer in gives
// exactly one transfer out (o_valid/i_stall) with result, duration, status.
// One item is worked on at a time; o_stall is high from acceptance until
// the result register is free again.
// Sequence: insert scans the sorted table from the end, moving entries up one
// at a time through the memories (IRD, IWAIT, IMOVE per entry moved), then
// writes the new entry (IPUT). Evaluate scans from the start (ERD, EWAIT,
// ECHK per entry read), then reads the entry below (EPRV), waits on the
// serial divider (EDIV) and does the multiply (EMUL) and add (EADD). After
// either, the last entry is read for the duration (DRD, DWAIT) before OUT.
// Reset clears the entry count and control state; the memories need no clearing.
// While the receiver stalls the result is held and no new item is taken.
module keyframe_curve_lerp
    import kcl_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_time_req,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_value,
    output logic [31:0] o_duration,
    output logic [1:0]  o_status
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_IRD, S_IWAIT, S_IMOVE, S_IPUT,
        S_ERD, S_EWAIT, S_ECHK, S_EPRV, S_EDIV, S_EMUL, S_EADD, S_DRD, S_DWAIT, S_OUT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_pos;
    logic signed [31:0] r_t;
    logic [31:0]        r_v;
    logic signed [31:0] r_t2;
    logic signed [31:0] r_v2;
    logic signed [31:0] r_v1;
    logic signed [33:0] r_dv;
    logic signed [51:0] r_prod;
    logic [QW-1:0]      r_dt;
    logic [QW-1:0]      r_span;
    logic               r_dstart;

    // memories
    logic [31:0] m_time [DEPTH];
    logic [31:0] m_val  [DEPTH];
    logic        r_we;
    logic [AW-1:0] r_wa;
    logic [31:0] r_wt;
    logic [31:0] r_wv;
    logic [AW-1:0] r_ra;
    logic [31:0] r_rt;
    logic [31:0] r_rv;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            m_time[r_wa] <= r_wt;
            m_val[r_wa]  <= r_wv;
        end
        r_rt <= m_time[r_ra];
        r_rv <= m_val[r_ra];
    end

    logic          w_ddone;
    logic [FW-1:0] w_frac;

    kcl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_dt    (r_dt),
        .i_span  (r_span),
        .o_done  (w_ddone),
        .o_frac  (w_frac)
    );

    logic signed [51:0] w_shr;
    assign w_shr = r_prod >>> 16;

    assign o_stall = (r_state != S_IDLE) || o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            o_valid  <= 1'b0;
            r_we     <= 1'b0;
            r_dstart <= 1'b0;
            r_dv     <= '0;
        end else begin
            r_we     <= 1'b0;
            r_dstart <= 1'b0;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_valid) begin
                        r_t  <= i_time_req;
                        r_v  <= i_value;
                        o_result_value <= '0;
                        o_status <= ST_OK;
                        if (i_op == OP_INSERT) begin
                            if (r_cnt == CW'(DEPTH)) begin
                                o_status <= ST_FULL;
                                r_state  <= S_DRD;
                            end else begin
                                r_pos   <= r_cnt;
                                r_state <= (r_cnt == '0) ? S_IPUT : S_IRD;
                            end
                        end else if (r_cnt == '0) begin
                            o_status <= ST_EMPTY;
                            r_state  <= S_OUT;
                        end else begin
                            r_pos   <= '0;
                            r_state <= S_ERD;
                        end
                    end
                end
                // insert: look at entry pos-1, move it up if its time is above
                S_IRD: begin
                    r_ra    <= AW'(r_pos - CW'(1));
                    r_state <= S_IWAIT;
                end
                S_IWAIT: r_state <= S_IMOVE;
                S_IMOVE: begin
                    if ($signed(r_rt) > r_t) begin
                        r_we  <= 1'b1;
                        r_wa  <= AW'(r_pos);
                        r_wt  <= r_rt;
                        r_wv  <= r_rv;
                        r_pos <= r_pos - CW'(1);
                        r_state <= (r_pos == CW'(1)) ? S_IPUT : S_IRD;
                    end else begin
                        r_state <= S_IPUT;
                    end
                end
                S_IPUT: begin
                    r_we  <= 1'b1;
                    r_wa  <= AW'(r_pos);
                    r_wt  <= r_t;
                    r_wv  <= r_v;
                    r_cnt <= r_cnt + CW'(1);
                    r_state <= S_DRD;
                end
                // evaluate: find first entry with time >= query
                S_ERD: begin
                    r_ra    <= AW'(r_pos);
                    r_state <= S_EWAIT;
                end
                S_EWAIT: r_state <= S_ECHK;
                S_ECHK: begin
                    if ($signed(r_rt) >= r_t) begin
                        if (r_pos == '0) begin
                            o_result_value <= r_rv;
                            r_state <= S_DRD;
                        end else begin
                            r_t2 <= r_rt;
                            r_v2 <= r_rv;
                            r_ra <= AW'(r_pos - CW'(1));
                            r_state <= S_EPRV;
                        end
                    end else if (r_pos == r_cnt - CW'(1)) begin
                        o_result_value <= r_rv;
                        r_state <= S_DRD;
                    end else begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_ERD;
                    end
                end
                S_EPRV: begin
                    // read data for pos-1 lands next cycle; reuse S_EWAIT timing
                    r_state <= S_EDIV;
                    r_cnt   <= r_cnt;
                end
                S_EDIV: begin
                    if (!r_dstart && r_span == '0 && r_dv == 34'sd1) begin
                        r_state <= S_EDIV;
                    end
                    if (r_dv != 34'sd1) begin
                        // first entry: launch the divide
                        r_v1   <= r_rv;
                        r_dv   <= 34'sd1;
                        r_dt   <= QW'($signed({r_t[31], r_t}) - $signed({r_rt[31], r_rt}));
                        r_span <= QW'($signed({r_t2[31], r_t2}) - $signed({r_rt[31], r_rt}));
                        r_dstart <= 1'b1;
                    end else if (w_ddone) begin
                        r_dv    <= 34'($signed(r_v2) - $signed(r_v1));
                        r_state <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    r_prod  <= r_dv * $signed({1'b0, w_frac});
                    r_state <= S_EADD;
                end
                S_EADD: begin
                    o_result_value <= 32'(r_v1 + w_shr[31:0]);
                    r_state <= S_DRD;
                end
                // duration: read the last entry
                S_DRD: begin
                    r_ra    <= AW'(r_cnt - CW'(1));
                    r_state <= S_DWAIT;
                end
                S_DWAIT: r_state <= S_OUT;
                S_OUT: begin
                    o_duration <= (r_cnt == '0) ? '0 : r_rt;
                    o_valid    <= 1'b1;
                    r_dv       <= '0;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/keyframe_curve_lerp_tb.sv @@
`timescale 1ns / 100ps
// keyframe_curve_lerp_tb: checks inserts and evaluates of the keyframe table
// against an in-bench sorted-table model; depends on kcl_pkg and the top level
module keyframe_curve_lerp_tb
    import kcl_pkg::*;
;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        op;
        logic [31:0] t;
        logic [31:0] v;
    } t_key_req;

    typedef struct packed {
        logic [31:0] res;
        logic [31:0] dur;
        logic [1:0]  st;
    } t_curve_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_op = 1'b0;
    logic [31:0] i_time_req = '0;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_result_value;
    logic [31:0] o_duration;
    logic [1:0]  o_status;

    keyframe_curve_lerp #(.DEPTH(DEPTH)) i_dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    t_key_req   pending_reqs[$];
    t_curve_res expected_curve[$];
    logic signed [31:0] tbl_time[DEPTH];
    logic signed [31:0] tbl_val[DEPTH];
    int  tbl_count = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_cycles = 0;
    bit  stim_done = 0;

    function automatic t_curve_res predict_curve(t_key_req r);
        t_curve_res o;
        int i;
        int pos;
        logic signed [31:0] q;
        logic signed [63:0] t1, t2, v1, v2, prod;
        logic [63:0] span, dt, frac;
        o = '0;
        q = r.t;
        if (r.op == OP_INSERT) begin
            if (tbl_count >= DEPTH) begin
                o.st = ST_FULL;
            end else begin
                pos = 0;
                while (pos < tbl_count && tbl_time[pos] <= q) pos++;
                for (i = tbl_count; i > pos; i--) begin
                    tbl_time[i] = tbl_time[i-1];
                    tbl_val[i] = tbl_val[i-1];
                end
                tbl_time[pos] = q;
                tbl_val[pos] = r.v;
                tbl_count++;
            end
        end else if (tbl_count == 0) begin
            o.st = ST_EMPTY;
        end else begin
            i = 0;
            while (i < tbl_count && tbl_time[i] < q) i++;
            if (i >= tbl_count) o.res = tbl_val[tbl_count-1];
            else if (i == 0) o.res = tbl_val[0];
            else begin
                t1 = tbl_time[i-1];
                t2 = tbl_time[i];
                v1 = tbl_val[i-1];
                v2 = tbl_val[i];
                span = t2 - t1;
                dt = 64'(q) - t1;
                if (span == 0) o.res = v1[31:0];
                else begin
                    frac = (dt << 16) / span;
                    if (frac > 65536) frac = 65536;
                    prod = (v2 - v1) * $signed(frac);
                    o.res = 32'(v1 + (prod >>> 16));
                end
            end
        end
        o.dur = (tbl_count == 0) ? 32'd0 : tbl_time[tbl_count-1];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // driver: bursts and gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_curve.push_back(predict_curve(pending_reqs.pop_front()));
            end
            if (i_valid && o_stall) begin
                // hold
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_key_req nx;
                nx = pending_reqs[0];
                i_valid <= 1'b1;
                i_op <= nx.op;
                i_time_req <= nx.t;
                i_value <= nx.v;
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_stall <= 1'b1;
            end else if (cycle_count == 3000) begin
                hold_cycles <= 1500;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (cycle_count % 512 < 128) ? 1'b0 : ($urandom_range(0, 3) == 0);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_curve.size() == 0) begin
                report_mismatch("unexpected transfer", o_result_value, 32'd0);
            end else begin
                t_curve_res e;
                e = expected_curve.pop_front();
                if (o_result_value !== e.res) report_mismatch("result", o_result_value, e.res);
                if (o_duration !== e.dur) report_mismatch("duration", o_duration, e.dur);
                if (o_status !== e.st) report_mismatch("status", 32'(o_status), 32'(e.st));
            end
        end
    end

    task automatic add_req(logic op, logic [31:0] t, logic [31:0] v);
        pending_reqs.push_back(t_key_req'{op, t, v});
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 8) << 16;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n;
        int k;
        int fill;
        logic [31:0] base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: empty evaluate, extremes, equal times, full table
        add_req(OP_EVAL, 32'd0, 32'hffff_ffff);
        add_req(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        add_req(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        add_req(OP_EVAL, 32'h0000_0000, 32'd0);
        add_req(OP_EVAL, 32'h8000_0000, 32'd0);
        add_req(OP_EVAL, 32'h7fff_ffff, 32'd0);
        add_req(OP_EVAL, 32'h8000_0001, 32'd0);
        add_req(OP_EVAL, 32'h7fff_fffe, 32'd0);
        add_req(OP_INSERT, 32'h0001_0000, 32'h0002_0000);
        add_req(OP_INSERT, 32'h0001_0000, 32'h0005_0000);
        add_req(OP_EVAL, 32'h0001_0000, 32'd0);
        add_req(OP_EVAL, 32'h0000_8000, 32'd0);
        while (pending_reqs.size() < 80)
            add_req(OP_INSERT, $urandom, $urandom);
        add_req(OP_EVAL, $urandom, 32'd0);
        wait (pending_reqs.size() == 0 && expected_curve.size() == 0);
        repeat (300) @(posedge i_clk);
        // random phase: mixed inserts and evaluates on the full table left by the directed part
        n = 0;
        while (n < 1870) begin
            wait (pending_reqs.size() < 8);
            if (tbl_count >= DEPTH || ($urandom_range(0, 9) == 0 && tbl_count > 12)) begin
                // cannot reset the table, so this branch does nothing
            end
            k = $urandom_range(0, 99);
            base = $urandom_range(0, 3) << 16;
            if (k < 45) add_req(OP_INSERT, ($urandom_range(0,1) ? rand_word() : base), rand_word());
            else if (k < 95) add_req(OP_EVAL, ($urandom_range(0,1) ? rand_word() : base + $urandom_range(0, 65535)), $urandom);
            else begin
                fill = $urandom_range(1, 3);
                repeat (fill) add_req(OP_INSERT, $urandom, $urandom);
                n += fill - 1;
            end
            n++;
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done && pending_reqs.size() == 0 && !i_valid && expected_curve.size() == 0);
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && expected_curve.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_div.sv
hw/rtl/keyframe_curve_lerp.sv
tb/keyframe_curve_lerp_tb.sv
